// File: src/adjm_pkg.sv
// Package: shared constants and operation/status codes for the adjacency matrix store.
package adjm_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 16;
	localparam int LIST_LIMIT       = 16;

	localparam logic [2:0] FN_ADD_V = 3'd0;
	localparam logic [2:0] FN_ADD_E = 3'd1;
	localparam logic [2:0] FN_REM_E = 3'd2;
	localparam logic [2:0] FN_ADJ   = 3'd3;
	localparam logic [2:0] FN_SUCC  = 3'd4;
	localparam logic [2:0] FN_PRED  = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_EXISTS  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef logic [1:0] status_t;

endpackage

// File: src/adjm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module adjm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/adjacency_matrix_store.sv
// Top level: weighted graph adjacency matrix held in one RAM, with a request sequencer.
//
// Usage: a request word (func, from_vertex, to_vertex, edge_weight) is taken on a
// rising edge with start high and busy low. Each result word appears on the result
// ports for one cycle with result_valid high; last marks the final word of a request.
// directed_mode is written through cfg_valid/cfg_ready (always ready); the user must
// write it only while idle, as the block itself does not enforce that. Steps per
// request, using the RAM's single read and single write port: an invalid vertex or
// full store is answered from idle with no RAM access; an adjacency test or an add
// onto an edge does one read, then answers; add edge reads, then writes, and mirrors
// the write when undirected; remove edge writes, and mirrors it when undirected; add
// vertex does one write per cycle clearing its row and column; a successor or
// predecessor list does one RAM read per vertex, ending early once 16 neighbours are
// listed. Results stream during the scan. func codes 6 and 7 give no result.
// Reset clears the vertex count and the mode; the RAM needs no clearing pass since a
// vertex's row and column are zeroed when it is added. The receiver cannot stall;
// results are registered so a new request can start while the last one is shown.
module adjacency_matrix_store #(
	parameter int MAX_VERTICES = adjm_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = adjm_pkg::WEIGHT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic [7:0]         from_vertex,
	input  logic [7:0]         to_vertex,
	input  logic signed [15:0] edge_weight,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               directed_mode,
	output logic               result_valid,
	output logic [1:0]         status,
	output logic               found,
	output logic [7:0]         neighbour,
	output logic signed [15:0] neighbour_weight,
	output logic               last
);

	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int VT_W   = $clog2(MAX_VERTICES + 1);
	localparam int CNT_W  = IDX_W + 1;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int HIT_W  = $clog2(adjm_pkg::LIST_LIMIT + 1);

	localparam logic signed [32:0] W_HI = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;
	localparam logic signed [32:0] O_HI = 33'sd32767;
	localparam logic signed [32:0] O_LO = -33'sd32768;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLR    = 3'd1;
	localparam logic [2:0] S_CHK    = 3'd2;
	localparam logic [2:0] S_MIRROR = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;

	logic [2:0]             state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [VT_W-1:0]        vt_q, vt_d;
	logic [HIT_W-1:0]       hits_q, hits_d;
	logic                   pend_v_q, pend_v_d;
	logic [IDX_W-1:0]       pend_idx_q, pend_idx_d;
	logic [WEIGHT_BITS-1:0] pend_w_q, pend_w_d;
	logic                   issue_s1, issue_d;
	logic [IDX_W-1:0]       idx_s1, idx_d;
	logic                   mode_q;

	logic [2:0]             func_q;
	logic [IDX_W-1:0]       a_q, b_q;
	logic [WEIGHT_BITS-1:0] w_q;

	logic                   rd_en, wr_en;
	logic [ADDR_W-1:0]      rd_addr, wr_addr;
	logic [WEIGHT_BITS-1:0] wr_data, rd_data;

	logic                   emit, e_found, e_last;
	adjm_pkg::status_t      e_status;
	logic [7:0]             e_nb;
	logic signed [15:0]     e_w;

	logic                   valid_q, found_q, last_q;
	adjm_pkg::status_t      status_q;
	logic [7:0]             nb_q;
	logic signed [15:0]     nw_q;

	logic                   accept, a_ok, b_ok, rd_pos, scan_end;
	logic signed [32:0]     in_ext, pend_ext;
	logic [WEIGHT_BITS-1:0] w_in_sat;
	logic signed [15:0]     pend_w16;
	logic [IDX_W-1:0]       si, ci;

	adjm_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign a_ok      = ({1'b0, from_vertex} < 9'(vt_q));
	assign b_ok      = ({1'b0, to_vertex} < 9'(vt_q));
	assign rd_pos    = !rd_data[WEIGHT_BITS-1] && (|rd_data);
	assign si        = cnt_q[IDX_W-1:0];
	assign ci        = cnt_q[CNT_W-1:1];
	assign scan_end  = (hits_q == HIT_W'(adjm_pkg::LIST_LIMIT))
	                || (!issue_s1 && (cnt_q >= CNT_W'(vt_q)));

	// saturate incoming weight to storage width, listed weight to 16 bits
	always_comb begin
		in_ext = 33'(edge_weight);
		if (in_ext > W_HI) begin
			w_in_sat = W_HI[WEIGHT_BITS-1:0];
		end else if (in_ext < W_LO) begin
			w_in_sat = W_LO[WEIGHT_BITS-1:0];
		end else begin
			w_in_sat = in_ext[WEIGHT_BITS-1:0];
		end
		pend_ext = 33'($signed(pend_w_q));
		if (pend_ext > O_HI) begin
			pend_w16 = O_HI[15:0];
		end else if (pend_ext < O_LO) begin
			pend_w16 = O_LO[15:0];
		end else begin
			pend_w16 = pend_ext[15:0];
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		vt_d       = vt_q;
		hits_d     = hits_q;
		pend_v_d   = pend_v_q;
		pend_idx_d = pend_idx_q;
		pend_w_d   = pend_w_q;
		issue_d    = 1'b0;
		idx_d      = idx_s1;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = '0;
		emit       = 1'b0;
		e_status   = adjm_pkg::ST_OK;
		e_found    = 1'b0;
		e_nb       = '0;
		e_w        = '0;
		e_last     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func) inside
						adjm_pkg::FN_ADD_V: begin
							if (vt_q == VT_W'(MAX_VERTICES)) begin
								emit     = 1'b1;
								e_status = adjm_pkg::ST_FULL;
							end else begin
								cnt_d   = '0;
								state_d = S_CLR;
							end
						end
						adjm_pkg::FN_ADD_E, adjm_pkg::FN_REM_E, adjm_pkg::FN_ADJ: begin
							if (!(a_ok && b_ok)) begin
								emit     = 1'b1;
								e_status = adjm_pkg::ST_INVALID;
							end else if (func == adjm_pkg::FN_REM_E) begin
								wr_en   = 1'b1;
								wr_addr = {from_vertex[IDX_W-1:0], to_vertex[IDX_W-1:0]};
								if (mode_q) begin
									emit = 1'b1;
								end else begin
									state_d = S_MIRROR;
								end
							end else begin
								rd_en   = 1'b1;
								rd_addr = {from_vertex[IDX_W-1:0], to_vertex[IDX_W-1:0]};
								state_d = S_CHK;
							end
						end
						adjm_pkg::FN_SUCC, adjm_pkg::FN_PRED: begin
							if (!a_ok) begin
								emit     = 1'b1;
								e_status = adjm_pkg::ST_INVALID;
							end else begin
								cnt_d    = '0;
								hits_d   = '0;
								pend_v_d = 1'b0;
								state_d  = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[0] ? {ci, vt_q[IDX_W-1:0]} : {vt_q[IDX_W-1:0], ci};
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(2 * MAX_VERTICES - 1)) begin
					vt_d    = vt_q + 1'b1;
					emit    = 1'b1;
					e_nb    = 8'(vt_q);
					state_d = S_IDLE;
				end
			end
			S_CHK: begin
				if (func_q == adjm_pkg::FN_ADJ) begin
					emit    = 1'b1;
					e_found = |rd_data;
					state_d = S_IDLE;
				end else if (|rd_data) begin
					emit     = 1'b1;
					e_status = adjm_pkg::ST_EXISTS;
					state_d  = S_IDLE;
				end else begin
					wr_en   = 1'b1;
					wr_addr = {a_q, b_q};
					wr_data = w_q;
					if (mode_q) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_MIRROR;
					end
				end
			end
			S_MIRROR: begin
				wr_en   = 1'b1;
				wr_addr = {b_q, a_q};
				wr_data = (func_q == adjm_pkg::FN_ADD_E) ? w_q : '0;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (scan_end) begin
					emit    = 1'b1;
					e_found = pend_v_q;
					e_nb    = pend_v_q ? 8'(pend_idx_q) : 8'd0;
					e_w     = pend_v_q ? pend_w16 : 16'sd0;
					state_d = S_IDLE;
				end else begin
					if (cnt_q < CNT_W'(vt_q)) begin
						rd_en   = 1'b1;
						rd_addr = (func_q == adjm_pkg::FN_SUCC) ? {a_q, si} : {si, a_q};
						issue_d = 1'b1;
						idx_d   = si;
						cnt_d   = cnt_q + 1'b1;
					end
					// hold one hit back so the final one can carry last
					if (issue_s1 && rd_pos) begin
						if (pend_v_q) begin
							emit    = 1'b1;
							e_found = 1'b1;
							e_nb    = 8'(pend_idx_q);
							e_w     = pend_w16;
							e_last  = 1'b0;
						end
						pend_v_d   = 1'b1;
						pend_idx_d = idx_s1;
						pend_w_d   = rd_data;
						hits_d     = hits_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			vt_q     <= '0;
			hits_q   <= '0;
			pend_v_q <= 1'b0;
			issue_s1 <= 1'b0;
			valid_q  <= 1'b0;
			mode_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			vt_q     <= vt_d;
			hits_q   <= hits_d;
			pend_v_q <= pend_v_d;
			issue_s1 <= issue_d;
			valid_q  <= emit;
			if (cfg_valid && cfg_ready) begin
				mode_q <= directed_mode;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_idx_q <= pend_idx_d;
		pend_w_q   <= pend_w_d;
		idx_s1     <= idx_d;
		if (accept) begin
			func_q <= func;
			a_q    <= from_vertex[IDX_W-1:0];
			b_q    <= to_vertex[IDX_W-1:0];
			w_q    <= w_in_sat;
		end
		if (emit) begin
			status_q <= e_status;
			found_q  <= e_found;
			nb_q     <= e_nb;
			nw_q     <= e_w;
			last_q   <= e_last;
		end
	end

	assign result_valid     = valid_q;
	assign status           = status_q;
	assign found            = found_q;
	assign neighbour        = nb_q;
	assign neighbour_weight = nw_q;
	assign last             = last_q;

`ifndef SYNTHESIS
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(busy) || $past(start)))
		else $error("result word without a request in flight");

	a_vt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vt_q <= VT_W'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en && (wr_addr == rd_addr)))
		else $error("read and write of one entry in the same cycle");

	a_hit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= HIT_W'(adjm_pkg::LIST_LIMIT))
		else $error("neighbour list longer than limit");
`endif

endmodule

// File: verif/tb_adjacency_matrix_store.sv
// Testbench: drives graph requests into adjacency_matrix_store and checks each result word.
module tb_adjacency_matrix_store;
	import adjm_pkg::*;

	localparam int MAX_V = MAX_VERTICES_DEF;
	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 2 * MAX_V + 8;
	localparam logic [2:0] FN_UNUSED_6 = 3'd6;
	localparam logic [2:0] FN_UNUSED_7 = 3'd7;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [7:0]         neighbour;
		logic signed [15:0] weight;
		logic               last;
	} graph_word_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         func = '0;
	logic [7:0]         from_vertex = '0;
	logic [7:0]         to_vertex = '0;
	logic signed [15:0] edge_weight = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               directed_mode = 1'b0;
	logic               result_valid;
	logic [1:0]         status;
	logic               found;
	logic [7:0]         neighbour;
	logic signed [15:0] neighbour_weight;
	logic               last;

	logic signed [15:0] weight_matrix [MAX_V][MAX_V];
	int                 vertex_count;
	logic               directed;
	graph_word_t        pending_words [$];
	int                 errors;
	logic               no_gaps;

	adjacency_matrix_store u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.from_vertex      (from_vertex),
		.to_vertex        (to_vertex),
		.edge_weight      (edge_weight),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.directed_mode    (directed_mode),
		.result_valid     (result_valid),
		.status           (status),
		.found            (found),
		.neighbour        (neighbour),
		.neighbour_weight (neighbour_weight),
		.last             (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		graph_word_t got;
		graph_word_t want;
		if (arst_n && result_valid) begin
			got = '{status, found, neighbour, neighbour_weight, last};
			if (pending_words.size() == 0) begin
				$display("%0t unexpected word: status=%0d found=%0d nb=%0d w=%0d last=%0d",
					$time, got.status, got.found, got.neighbour, got.weight, got.last);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (got !== want) begin
					$display("%0t mismatch: expected status=%0d found=%0d nb=%0d w=%0d last=%0d",
						$time, want.status, want.found, want.neighbour, want.weight, want.last);
					$display("%0t          actual   status=%0d found=%0d nb=%0d w=%0d last=%0d",
						$time, got.status, got.found, got.neighbour, got.weight, got.last);
					errors++;
				end
			end
		end
	end

	function automatic void queue_word(input graph_word_t wd);
		pending_words.insert(pending_words.size(), wd);
	endfunction

	task automatic graph_update(input logic [2:0] f, input logic [7:0] a, input logic [7:0] b,
		input logic signed [15:0] w);
		graph_word_t r;
		int hits;
		r = '{status: ST_OK, found: 1'b0, neighbour: 8'd0, weight: 16'sd0, last: 1'b1};
		case (f)
		FN_ADD_V: begin
			if (vertex_count >= MAX_V) begin
				r.status = ST_FULL;
			end else begin
				for (int i = 0; i < MAX_V; i++) begin
					weight_matrix[vertex_count][i] = '0;
					weight_matrix[i][vertex_count] = '0;
				end
				r.neighbour = 8'(vertex_count);
				vertex_count++;
			end
			queue_word(r);
		end
		FN_ADD_E, FN_REM_E, FN_ADJ: begin
			if (a >= vertex_count || b >= vertex_count) begin
				r.status = ST_INVALID;
			end else if (f == FN_ADJ) begin
				r.found = (weight_matrix[a][b] != 0);
			end else if (f == FN_ADD_E && weight_matrix[a][b] != 0) begin
				r.status = ST_EXISTS;
			end else begin
				weight_matrix[a][b] = (f == FN_ADD_E) ? w : 16'sd0;
				if (!directed)
					weight_matrix[b][a] = (f == FN_ADD_E) ? w : 16'sd0;
			end
			queue_word(r);
		end
		FN_SUCC, FN_PRED: begin
			hits = 0;
			if (a >= vertex_count) begin
				r.status = ST_INVALID;
				queue_word(r);
			end else begin
				for (int i = 0; i < vertex_count && hits < LIST_LIMIT; i++) begin
					graph_word_t n;
					n = '{status: ST_OK, found: 1'b1, neighbour: i[7:0],
						weight: (f == FN_SUCC) ? weight_matrix[a][i] : weight_matrix[i][a],
						last: 1'b0};
					if (n.weight > 0) begin
						queue_word(n);
						hits++;
					end
				end
				if (hits == 0)
					queue_word(r);
				else
					pending_words[pending_words.size() - 1].last = 1'b1;
			end
		end
		default: ;
		endcase
	endtask

	task automatic send_request(input logic [2:0] f, input logic [7:0] a, input logic [7:0] b,
		input logic signed [15:0] w);
		while (!no_gaps && $urandom_range(0, 99) < 21) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		func        <= f;
		from_vertex <= a;
		to_vertex   <= b;
		edge_weight <= w;
		do @(posedge clk); while (busy);
		graph_update(f, a, b, w);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_direction(input logic mode);
		drain();
		cfg_valid     <= 1'b1;
		directed_mode <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		directed = mode;
	endtask

	function automatic logic [7:0] pick_vertex();
		if (vertex_count > 0 && $urandom_range(0, 9) != 0)
			return 8'($urandom_range(0, vertex_count - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_request(input int add_vertex_pct);
		int pick;
		logic [2:0] f;
		logic signed [15:0] w;
		pick = $urandom_range(0, 99);
		if (pick < add_vertex_pct) begin
			f = FN_ADD_V;
		end else if (pick < add_vertex_pct + 3) begin
			f = $urandom_range(0, 1) ? FN_UNUSED_6 : FN_UNUSED_7;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 36)      f = FN_ADD_E;
			else if (pick < 50) f = FN_REM_E;
			else if (pick < 65) f = FN_ADJ;
			else if (pick < 82) f = FN_SUCC;
			else                f = FN_PRED;
		end
		case ($urandom_range(0, 9))
		0:       w = 16'sd0;
		1:       w = 16'sh7fff;
		2:       w = 16'sh8000;
		3, 4:    w = 16'($urandom_range(0, 65535));
		default: w = 16'($urandom_range(1, 32767));
		endcase
		send_request(f, pick_vertex(), pick_vertex(), w);
	endtask

	task automatic test_empty_store();
		send_request(FN_ADJ, 8'd0, 8'd0, 16'sd0);
		send_request(FN_SUCC, 8'd0, 8'd0, 16'sd0);
		send_request(FN_ADD_E, 8'd0, 8'd0, 16'sd5);
		send_request(FN_PRED, 8'd255, 8'd255, 16'shffff);
		send_request(FN_UNUSED_6, 8'd0, 8'd0, 16'sd0);
		send_request(FN_UNUSED_7, 8'd255, 8'd255, 16'shffff);
	endtask

	task automatic test_undirected_edges();
		set_direction(1'b0);
		repeat (3) send_request(FN_ADD_V, 8'd0, 8'd0, 16'sd0);
		send_request(FN_ADD_E, 8'd0, 8'd1, 16'sh7fff);
		send_request(FN_ADD_E, 8'd1, 8'd0, 16'sd3);
		send_request(FN_ADD_E, 8'd1, 8'd2, 16'sh8000);
		send_request(FN_ADD_E, 8'd2, 8'd2, 16'sd0);
		send_request(FN_ADJ, 8'd2, 8'd2, 16'sd0);
		send_request(FN_ADJ, 8'd2, 8'd1, 16'sd0);
		send_request(FN_SUCC, 8'd1, 8'd0, 16'sd0);
		send_request(FN_PRED, 8'd2, 8'd0, 16'sd0);
		send_request(FN_REM_E, 8'd1, 8'd0, 16'sd0);
		send_request(FN_SUCC, 8'd0, 8'd0, 16'sd0);
		send_request(FN_ADD_E, 8'd0, 8'd3, 16'sd9);
	endtask

	task automatic test_directed_edges();
		set_direction(1'b1);
		send_request(FN_ADD_E, 8'd2, 8'd0, 16'sd7);
		send_request(FN_ADJ, 8'd0, 8'd2, 16'sd0);
		send_request(FN_PRED, 8'd0, 8'd0, 16'sd0);
		send_request(FN_SUCC, 8'd2, 8'd0, 16'sd0);
	endtask

	task automatic test_grow_to_full();
		set_direction(1'b0);
		repeat (110) random_request(12);
		while (vertex_count < MAX_V) send_request(FN_ADD_V, 8'd0, 8'd0, 16'sd0);
		send_request(FN_ADD_V, 8'd0, 8'd0, 16'sd0);
	endtask

	// hub gets an edge to every vertex so the list hits its cap
	task automatic test_long_list();
		logic [7:0] hub;
		set_direction(1'b1);
		no_gaps = 1'b1;
		hub = 8'($urandom_range(0, MAX_V - 1));
		for (int v = 0; v < MAX_V; v++) begin
			send_request(FN_REM_E, hub, v[7:0], 16'sd0);
			send_request(FN_ADD_E, hub, v[7:0], 16'($urandom_range(1, 32767)));
		end
		send_request(FN_SUCC, hub, 8'd0, 16'sd0);
		send_request(FN_PRED, hub, 8'd0, 16'sd0);
		no_gaps = 1'b0;
	endtask

	task automatic test_random_traffic(input logic mode, input int count, input int add_pct);
		set_direction(mode);
		repeat (count) random_request(add_pct);
	endtask

	initial begin
		vertex_count = 0;
		directed = 1'b0;
		errors = 0;
		no_gaps = 1'b0;
		for (int i = 0; i < MAX_V; i++)
			for (int j = 0; j < MAX_V; j++)
				weight_matrix[i][j] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_undirected_edges();
		test_directed_edges();
		test_grow_to_full();
		test_long_list();
		test_random_traffic(1'b0, 90, 2);
		test_random_traffic(1'b1, 90, 2);
		test_random_traffic(1'b0, 80, 1);
		drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
